// File: design/sbf_pkg.sv
// Package for the STX/ETX byte-stuffing framer: framing byte codes, the
// escape test and the struct that carries one item's run of link bytes.
// No dependencies; the encoder, serializer and top-level files import it.
`default_nettype none

package sbf_pkg;

  localparam logic [7:0] START_BYTE  = 8'h02;
  localparam logic [7:0] STOP_BYTE   = 8'h03;
  localparam logic [7:0] ESCAPE_BYTE = 8'h10;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam int unsigned MAX_RUN = 4;

  // One input item expands into up to four link bytes.
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [1:0]              last_idx;
  } run_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == START_BYTE) || (b == STOP_BYTE) || (b == ESCAPE_BYTE);
  endfunction

endpackage

`default_nettype wire

// File: design/sbf_if.sv
// Valid/ready channel interfaces of the framer: the item channel in and
// the link byte channel out. Depends on nothing.
`default_nettype none

interface sbf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface sbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: design/sbf_encoder.sv
// Input register and packet state of the framer; builds the run of link
// bytes for the held item. Depends on sbf_pkg and sbf_in_if.
`default_nettype none

module sbf_encoder
  import sbf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  sbf_in_if.sink     in_ch,
  input  wire logic  take,
  output logic       enc_valid,
  output run_t       run
);

  logic       hold_v_r,      hold_v_nxt;
  logic       hold_action_r;
  logic [7:0] hold_data_r;
  logic       in_packet_r,   in_packet_nxt;
  logic [7:0] sum_r,         sum_nxt;

  logic       in_fire;
  logic [7:0] val;
  logic [2:0] n;

  // The held item may be replaced in the same cycle it is passed on.
  assign in_ch.ready = !hold_v_r || take;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign enc_valid   = hold_v_r;

  always_comb begin
    hold_v_nxt = in_fire ? 1'b1 : (take ? 1'b0 : hold_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_action_r <= in_ch.action;
      hold_data_r   <= in_ch.data_byte;
    end
  end

  // Lay the run out slot by slot: optional start, optional escape, the
  // value itself, and the stop byte after a checksum.
  always_comb begin
    run.bytes = '0;
    n         = 3'd0;
    val       = (hold_action_r == ACT_END) ? ~sum_r : hold_data_r;
    if (!in_packet_r) begin
      run.bytes[n[1:0]] = START_BYTE;
      n = n + 3'd1;
    end
    if (needs_escape(val)) begin
      run.bytes[n[1:0]] = ESCAPE_BYTE;
      n = n + 3'd1;
    end
    run.bytes[n[1:0]] = val;
    n = n + 3'd1;
    if (hold_action_r == ACT_END) begin
      run.bytes[n[1:0]] = STOP_BYTE;
      n = n + 3'd1;
    end
    run.last_idx = 2'(n - 3'd1);
  end

  always_comb begin
    in_packet_nxt = in_packet_r;
    sum_nxt       = sum_r;
    if (take) begin
      if (hold_action_r == ACT_END) begin
        in_packet_nxt = 1'b0;
        sum_nxt       = 8'h00;
      end else begin
        in_packet_nxt = 1'b1;
        sum_nxt       = sum_r + hold_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      sum_r       <= 8'h00;
    end else begin
      in_packet_r <= in_packet_nxt;
      sum_r       <= sum_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    take && hold_action_r == ACT_END |=> !in_packet_r && sum_r == 8'h00)
    else $error("packet state not cleared after end mark");

  a_end_has_stop: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r && hold_action_r == ACT_END |-> run.bytes[run.last_idx] == STOP_BYTE)
    else $error("end-mark run does not finish with stop byte");

  a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r && !take |=> hold_v_r && $stable(hold_data_r) && $stable(hold_action_r))
    else $error("held item lost before it was passed on");
`endif

endmodule

`default_nettype wire

// File: design/sbf_serializer.sv
// Run register of the framer: sends one item's link bytes one beat at a
// time and asks for the next run. Depends on sbf_pkg and sbf_out_if.
`default_nettype none

module sbf_serializer
  import sbf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  enc_valid,
  input  wire run_t  run,
  output logic       take,
  sbf_out_if.source  out_ch
);

  run_t       run_r;
  logic       run_v_r, run_v_nxt;
  logic [1:0] idx_r,   idx_nxt;
  logic       at_last;
  logic       out_fire;

  assign at_last  = (idx_r == run_r.last_idx);
  assign out_fire = out_ch.valid && out_ch.ready;
  // A new run loads when the register is empty or its last beat leaves.
  assign take     = enc_valid && (!run_v_r || (out_fire && at_last));

  assign out_ch.valid       = run_v_r;
  assign out_ch.out_byte    = run_r.bytes[idx_r];
  assign out_ch.last_of_run = at_last;

  always_comb begin
    run_v_nxt = run_v_r;
    idx_nxt   = idx_r;
    if (take) begin
      run_v_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (out_fire) begin
      if (at_last) begin
        run_v_nxt = 1'b0;
        idx_nxt   = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      run_v_r <= run_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      run_r <= run;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_v_r |-> idx_r <= run_r.last_idx)
    else $error("byte index ran past end of run");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> run_v_r && idx_r == 2'd0)
    else $error("loaded run does not start at its first byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !run_v_r || (out_fire && at_last))
    else $error("run overwritten before its last beat");
`endif

endmodule

`default_nettype wire

// File: design/stx_etx_byte_stuffing_framer.sv
// STX/ETX byte-stuffing framer. Each accepted item (a payload byte or an
// end-of-packet mark) yields one to four link bytes: start byte 0x02 when
// no packet is open, escape 0x10 before any 0x02/0x03/0x10 value, the
// payload byte, or at an end mark the checksum (0xFF minus the 8-bit
// payload sum) followed by stop byte 0x03. last_of_run flags an item's
// final byte. An item's link bytes (1 to 4) leave one byte per accepted
// beat from the run register; a second item is held in the input
// register meanwhile and loads as the last byte of the run leaves, while
// the input waits until the held item has been passed on.
`default_nettype none

module stx_etx_byte_stuffing_framer
  import sbf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  sbf_in_if.sink     in_ch,
  sbf_out_if.source  out_ch
);

  logic take;
  logic enc_valid;
  run_t run;

  sbf_encoder u_encoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .take      (take),
    .enc_valid (enc_valid),
    .run       (run)
  );

  sbf_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .enc_valid (enc_valid),
    .run       (run),
    .take      (take),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
